// File: design/bee_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bee_pkg: shared types and constants of the byte entropy estimator
// Histogram and log widths, queue geometry and the payload structs.
// ----------------------------------------------------------------------------
package bee_pkg;

  localparam int MAX_LEN       = 4096;
  localparam int LOG_FRAC_BITS = 16;

  localparam int SYM_W       = 8;
  localparam int NUM_BINS    = 256;
  localparam int BIN_W       = 8;
  localparam int EST_W       = 16;
  localparam int THR_W       = 16;
  localparam int THR_RESET   = 80;

  // count of one bin or of the whole string
  localparam int CNT_W  = $clog2(MAX_LEN + 1);
  // integer part of the log holds the top-bit index of a count
  localparam int E_W    = $clog2(CNT_W);
  localparam int LOG_W  = E_W + LOG_FRAC_BITS;
  localparam int FI_W   = $clog2(LOG_FRAC_BITS);
  localparam int PROD_W = CNT_W + LOG_W;
  localparam int SUM_W  = (PROD_W + 1 > EST_W + LOG_FRAC_BITS + 1) ?
                          PROD_W + 1 : EST_W + LOG_FRAC_BITS + 1;

  // log mantissa, unsigned Q1.62, squared in 32-bit halves
  localparam int MANT_W = 63;
  localparam int HALF_W = 32;
  localparam int ACC_W  = 2 * MANT_W;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [SYM_W-1:0] byte_value;
    logic             last_byte;
  } bee_in_t;

  typedef struct packed {
    logic [EST_W-1:0] entropy_bits;
    logic             below_threshold;
    logic             length_overflow;
  } bee_out_t;

  typedef struct packed {
    logic [SYM_W-1:0] sym;
    logic             inc;   // byte is binned (not beyond the length limit)
    logic             last;
    logic             ovf;   // string has dropped bytes so far
    logic [CNT_W-1:0] len;   // string length including this byte, capped at MAX_LEN
  } bee_entry_t;

  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] x;
  } bee_log_req_t;

  typedef struct packed {
    logic             done;
    logic [LOG_W-1:0] result;
  } bee_log_rsp_t;

endpackage
`default_nettype wire

// File: design/byte_entropy_estimator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// byte_entropy_estimator: fixed-point Shannon entropy estimate of byte strings
// Bytes: binned one at a time by a read-modify-write of the bin memory.
// End of string: a walk over all 256 bins, one log per distinct
//   byte value and one for the length term, from the iterative log unit.
// The result is registered after that walk and held until it is taken.
// Reset: a pass over all 256 bins clears them; no byte is taken meanwhile.
// ----------------------------------------------------------------------------
module byte_entropy_estimator import bee_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire bee_in_t          in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output bee_out_t              out_data_o,
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic [THR_W-1:0] cfg_data_i
);

  // Threshold register: one register, always ready for a transfer.
  logic [THR_W-1:0] thr_q, thr_d;

  // Front to queue and queue to back.
  logic       q_push, q_pop, q_full, q_empty;
  bee_entry_t q_entry, q_head;
  logic       clearing;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    thr_d = thr_q;
    if (cfg_valid_i) thr_d = cfg_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_W'(THR_RESET);
    end else begin
      thr_q <= thr_d;
    end
  end

  // Front: take bytes, count length, flag those beyond the length limit.
  bee_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .clearing_i (clearing),
    .push_o     (q_push),
    .entry_o    (q_entry)
  );

  // Queue: lets the front keep taking bytes while the back is busy.
  bee_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_entry),
    .pop_i   (q_pop),
    .head_o  (q_head),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  // Back: bin in-limit bytes, then walk, clear and sum the bins at string end.
  bee_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .thr_i       (thr_q),
    .clearing_o  (clearing),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

`ifndef ASSERT_OFF
  a_no_input_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !in_ready_o)
    else $error("byte transfer during bin clearing pass");

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("queue push while full");

  a_no_pop_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("queue pop while empty");
`endif

endmodule
`default_nettype wire

// File: design/bee_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bee_front: input acceptance and classification
// Counts string length, marks bytes beyond the limit and pushes work entries.
// ----------------------------------------------------------------------------
module bee_front import bee_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire bee_in_t    in_data_i,
  input  wire logic       q_full_i,
  input  wire logic       clearing_i,
  output logic            push_o,
  output bee_entry_t      entry_o
);

  logic [CNT_W-1:0] len_q, len_d;
  logic             ovf_q, ovf_d;
  logic             inc;
  logic [CNT_W-1:0] len_next;
  logic             ovf_next;

  assign in_ready_o = ~q_full_i & ~clearing_i;
  assign push_o     = in_valid_i & in_ready_o;

  assign inc      = (len_q < CNT_W'(MAX_LEN));
  assign len_next = inc ? len_q + CNT_W'(1) : len_q;
  assign ovf_next = ovf_q | ~inc;

  always_comb begin
    entry_o.sym  = in_data_i.byte_value;
    entry_o.inc  = inc;
    entry_o.last = in_data_i.last_byte;
    entry_o.ovf  = ovf_next;
    entry_o.len  = len_next;
  end

  always_comb begin
    len_d = len_q;
    ovf_d = ovf_q;
    if (push_o) begin
      // restart the count after the closing byte
      len_d = in_data_i.last_byte ? '0 : len_next;
      ovf_d = in_data_i.last_byte ? 1'b0 : ovf_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
      ovf_q <= 1'b0;
    end else begin
      len_q <= len_d;
      ovf_q <= ovf_d;
    end
  end

endmodule
`default_nettype wire

// File: design/bee_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bee_queue: short work queue between front and back
// Circular buffer of work entries with full and empty status.
// ----------------------------------------------------------------------------
module bee_queue import bee_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  input  wire bee_entry_t  entry_i,
  input  wire logic        pop_i,
  output bee_entry_t       head_o,
  output logic             full_o,
  output logic             empty_o
);

  bee_entry_t        slots_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QPTR_W:0]   cnt_q;

  assign full_o  = (cnt_q == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = slots_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + QPTR_W'(1);
      if (pop_i)  rd_q <= rd_q + QPTR_W'(1);
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + (QPTR_W+1)'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - (QPTR_W+1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slots_q[wr_q] <= entry_i;
  end

endmodule
`default_nettype wire

// File: design/bee_log.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bee_log: iterative fixed-point base-2 logarithm
// One fraction bit per pass of four phases: the Q1.62 mantissa is squared
// from three 32x32 partial products on one shared multiplier.
// ----------------------------------------------------------------------------
module bee_log import bee_pkg::*; (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire bee_log_req_t  req_i,
  output bee_log_rsp_t       rsp_o
);

  localparam int SH_W = $clog2(MANT_W);
  localparam int SQ_W = ACC_W - MANT_W + 1;

  localparam logic [1:0] PH_LL   = 2'd0;
  localparam logic [1:0] PH_LH   = 2'd1;
  localparam logic [1:0] PH_HH   = 2'd2;
  localparam logic [1:0] PH_FOLD = 2'd3;

  logic                     busy_q;
  logic                     done_q;
  logic [1:0]               phase_q;
  logic [FI_W-1:0]          i_q;
  logic [E_W-1:0]           e_q;
  logic [LOG_FRAC_BITS-1:0] frac_q;
  logic [MANT_W-1:0]        m_q;
  logic [2*HALF_W-1:0]      prod_q;
  logic [ACC_W-1:0]         acc_q;

  logic [E_W-1:0]      e_start;
  logic [MANT_W-1:0]   m_start;
  logic [HALF_W-1:0]   lo_half, hi_half, mul_a, mul_b;
  logic [2*HALF_W-1:0] mul_p;
  logic [ACC_W-1:0]    sq_full;
  logic [SQ_W-1:0]     sq;

  // top set bit of the argument
  always_comb begin
    e_start = '0;
    for (int k = 0; k < CNT_W; k++) begin
      if (req_i.x[k]) e_start = E_W'(k);
    end
  end

  assign m_start = MANT_W'(req_i.x) << (SH_W'(MANT_W - 1) - SH_W'(e_start));

  assign lo_half = m_q[HALF_W-1:0];
  assign hi_half = HALF_W'(m_q[MANT_W-1:HALF_W]);

  always_comb begin
    case (phase_q)
      PH_LL: begin
        mul_a = lo_half;
        mul_b = lo_half;
      end
      PH_LH: begin
        mul_a = lo_half;
        mul_b = hi_half;
      end
      default: begin
        mul_a = hi_half;
        mul_b = hi_half;
      end
    endcase
  end

  assign mul_p   = mul_a * mul_b;
  assign sq_full = acc_q + (ACC_W'(prod_q) << (2 * HALF_W));
  assign sq      = sq_full[ACC_W-1:MANT_W-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      phase_q <= PH_LL;
      i_q     <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q  <= 1'b1;
        phase_q <= PH_LL;
        i_q     <= FI_W'(LOG_FRAC_BITS - 1);
      end else if (busy_q) begin
        phase_q <= phase_q + 2'd1;
        if (phase_q == PH_FOLD) begin
          if (i_q == '0) begin
            busy_q <= 1'b0;
            done_q <= 1'b1;
          end else begin
            i_q <= i_q - FI_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      e_q    <= e_start;
      m_q    <= m_start;
      frac_q <= '0;
    end else if (busy_q) begin
      prod_q <= mul_p;
      case (phase_q)
        PH_LH:   acc_q <= ACC_W'(prod_q);
        PH_HH:   acc_q <= acc_q + (ACC_W'(prod_q) << (HALF_W + 1));
        PH_FOLD: begin
          // square at or above 2.0: emit a one and halve
          frac_q[i_q] <= sq[SQ_W-1];
          m_q         <= sq[SQ_W-1] ? sq[SQ_W-1:1] : sq[SQ_W-2:0];
        end
        default: acc_q <= acc_q;
      endcase
    end
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.result = {e_q, frac_q};

endmodule
`default_nettype wire

// File: design/bee_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bee_back: histogram update, end-of-string walk and result register
// Bins bytes by read-modify-write, walks and clears the bins at string end.
// ----------------------------------------------------------------------------
module bee_back import bee_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        q_empty_i,
  input  wire bee_entry_t  q_head_i,
  output logic             q_pop_o,
  input  wire logic [THR_W-1:0] thr_i,
  output logic             clearing_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output bee_out_t         out_data_o
);

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_UPD  = 4'd2;
  localparam logic [3:0] S_WRD  = 4'd3;
  localparam logic [3:0] S_WCHK = 4'd4;
  localparam logic [3:0] S_LOG  = 4'd5;
  localparam logic [3:0] S_MUL  = 4'd6;
  localparam logic [3:0] S_ACC  = 4'd7;
  localparam logic [3:0] S_TOT  = 4'd8;
  localparam logic [3:0] S_FIN  = 4'd9;

  logic [CNT_W-1:0] hist_mem [NUM_BINS];
  logic             mem_we;
  logic [BIN_W-1:0] mem_waddr, mem_raddr;
  logic [CNT_W-1:0] mem_wdata;
  logic [CNT_W-1:0] rd_q;

  logic [3:0]       state_q, state_d;
  logic [BIN_W-1:0] b_q, b_d;
  logic             tot_q, tot_d;
  logic [SUM_W-1:0] sum_q, sum_d;
  logic             out_valid_q, out_valid_d;
  bee_out_t         out_q, out_d;
  logic             out_load;

  bee_entry_t        cur_q;
  logic [CNT_W-1:0]  x_q;
  logic [PROD_W-1:0] mprod_q, total_q;

  bee_log_req_t log_req;
  bee_log_rsp_t log_rsp;

  logic [SUM_W-1:0] total_ext, diff;
  logic [EST_W-1:0] est;

  bee_log u_log (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (log_req),
    .rsp_o  (log_rsp)
  );

  assign total_ext = SUM_W'(total_q);
  assign diff      = (total_ext > sum_q) ? total_ext - sum_q : '0;
  assign est = (diff[SUM_W-1:LOG_FRAC_BITS+EST_W] != '0) ? {EST_W{1'b1}} :
               diff[LOG_FRAC_BITS+EST_W-1:LOG_FRAC_BITS];

  always_comb begin
    state_d   = state_q;
    b_d       = b_q;
    tot_d     = tot_q;
    sum_d     = sum_q;
    mem_we    = 1'b0;
    mem_waddr = b_q;
    mem_wdata = '0;
    mem_raddr = b_q;
    q_pop_o   = 1'b0;
    log_req   = '0;
    out_load  = 1'b0;
    out_d     = out_q;

    unique case (state_q)
      S_CLR: begin
        mem_we = 1'b1;
        b_d    = b_q + BIN_W'(1);
        if (&b_q) state_d = S_IDLE;
      end
      S_IDLE: begin
        mem_raddr = q_head_i.sym;
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          state_d = S_UPD;
        end
      end
      S_UPD: begin
        if (cur_q.inc) begin
          mem_we    = 1'b1;
          mem_waddr = cur_q.sym;
          mem_wdata = rd_q + CNT_W'(1);
        end
        if (cur_q.last) begin
          b_d     = '0;
          state_d = S_WRD;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_WRD: begin
        state_d = S_WCHK;
      end
      S_WCHK: begin
        // clear the bin as it is read
        mem_we = 1'b1;
        if (rd_q != '0) begin
          log_req.start = 1'b1;
          log_req.x     = rd_q;
          state_d       = S_LOG;
        end else if (&b_q) begin
          state_d = S_TOT;
        end else begin
          b_d     = b_q + BIN_W'(1);
          state_d = S_WRD;
        end
      end
      S_LOG: begin
        if (log_rsp.done) state_d = S_MUL;
      end
      S_MUL: begin
        state_d = S_ACC;
      end
      S_ACC: begin
        if (tot_q) begin
          state_d = S_FIN;
        end else begin
          sum_d = sum_q + SUM_W'(mprod_q);
          if (&b_q) begin
            state_d = S_TOT;
          end else begin
            b_d     = b_q + BIN_W'(1);
            state_d = S_WRD;
          end
        end
      end
      S_TOT: begin
        log_req.start = 1'b1;
        log_req.x     = cur_q.len;
        tot_d         = 1'b1;
        state_d       = S_LOG;
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_load                    = 1'b1;
          out_d.entropy_bits          = est;
          out_d.below_threshold       = (est < thr_i);
          out_d.length_overflow       = cur_q.ovf;
          sum_d                       = '0;
          tot_d                       = 1'b0;
          state_d                     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      b_q         <= '0;
      tot_q       <= 1'b0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      b_q         <= b_d;
      tot_q       <= tot_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) cur_q <= q_head_i;
    if (log_req.start) x_q <= log_req.x;
    if (state_q == S_MUL) mprod_q <= PROD_W'(x_q) * PROD_W'(log_rsp.result);
    if (state_q == S_ACC && tot_q) total_q <= mprod_q;
    out_q <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) hist_mem[mem_waddr] <= mem_wdata;
    rd_q <= hist_mem[mem_raddr];
  end

  assign clearing_o  = (state_q == S_CLR);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire
